/* src/assert_macros.svh */
// shared assertion macros, clocked on i_clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define NBS_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("nbs assertion failed");

// antecedent implies consequent in the same cycle
`define NBS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nbs implication failed");

// antecedent implies consequent in the next cycle
`define NBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nbs next-cycle check failed");

`endif

/* src/nbs_pkg.sv */
package nbs_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int COORD_BITS  = 16;
    localparam int RANK_W      = 12;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int MID_W  = COORD_BITS + 1;
    localparam int SQ_W   = 2 * MID_W;
    localparam int DIST_W = SQ_W + 1;

    // search starts below a plain distance of ten million
    localparam int CMP_W = (DIST_W > 47) ? DIST_W : 47;
    localparam logic [CMP_W-1:0] START_BOUND_SQ = CMP_W'(64'd100_000_000_000_000);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    // x in the lowest bits, as on the stream
    typedef struct packed {
        logic [RANK_W-1:0]     rank;
        logic                  horizontal;
        logic [COORD_BITS-1:0] length;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [DIST_W-1:0] dist_sq;
        t_entry            entry;
        logic [IDX_W-1:0]  idx;
    } t_result;

    // walk tag that follows each table read down the pipeline
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

    localparam int IN_FIELDS_W  = ENTRY_W + 2 * COORD_BITS;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = $bits(t_result);
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

/* src/nearest_border_neighbour_select.sv */
// clear and append give no result
// query: result is given once every entry has been compared (no walk on an
//   empty table), one table entry read per cycle through the single read port
// one item in work at a time; a waiting result does not block clear or append
// reset (synchronous, active low) empties the table, idles the walker and drops
//   any pending result; table memory contents are not cleared
`include "assert_macros.svh"

module nearest_border_neighbour_select (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // entry_x, entry_y, entry_length, entry_horizontal, entry_rank, query_x,
    // query_y, zero pad
    input  logic [nbs_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // op
    input  logic [1:0]                        i_s_tuser,
    // master side
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // best_index, best_x, best_y, best_length, best_horizontal, best_rank,
    // best_distance_sq, zero pad
    output logic [nbs_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // found
    output logic [0:0]                        o_m_tuser
);
    import nbs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_OUT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    t_op                   w_op;
    t_entry                w_in_entry;
    logic                  w_s_fire;
    logic                  w_we;
    logic                  w_issue;
    logic                  w_out_free;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_rd_cnt;
    logic [COORD_BITS-1:0] r_qx;
    logic [COORD_BITS-1:0] r_qy;
    t_tag                  r_tag0;
    t_entry                w_rd_entry;

    t_tag                  w_tag3;
    t_entry                w_entry3;
    logic [SQ_W-1:0]       w_sx;
    logic [SQ_W-1:0]       w_sy;
    logic [DIST_W-1:0]     w_dist;
    logic                  w_better;

    logic [CMP_W-1:0]      r_bound;
    logic                  r_found;
    t_result               r_best;

    logic                  r_m_valid;
    logic                  r_m_found;
    t_result               r_m_data;

    // input unpacking: entry fields from the bottom, query point above them
    assign w_op       = t_op'(i_s_tuser);
    assign w_in_entry = t_entry'(i_s_tdata[ENTRY_W-1:0]);

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_s_fire   = i_s_tvalid && o_s_tready;

    // appends past the end of the table are dropped
    assign w_we    = w_s_fire && (w_op == OP_APPEND) && (r_count < CNT_W'(TABLE_DEPTH));
    assign w_issue = (r_state == ST_WALK) && (r_rd_cnt < r_count);

    nbs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_in_entry),
        .i_re    (w_issue),
        .i_raddr (r_rd_cnt[IDX_W-1:0]),
        .o_rdata (w_rd_entry)
    );

    // midpoint distance pipeline, two stages after the memory read
    nbs_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag0),
        .i_entry (w_rd_entry),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_tag   (w_tag3),
        .o_entry (w_entry3),
        .o_sx    (w_sx),
        .o_sy    (w_sy)
    );

    // squared distance and strict compare against the running bound
    assign w_dist   = DIST_W'(w_sx) + DIST_W'(w_sy);
    assign w_better = (CMP_W'(w_dist) < r_bound);

    assign w_out_free = !r_m_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_fire && (w_op == OP_QUERY)) begin
                    n_state = (r_count == '0) ? ST_OUT : ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_tag3.valid && w_tag3.last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_rd_cnt  <= '0;
            r_tag0    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_s_fire && (w_op == OP_CLEAR)) begin
                r_count <= '0;
            end else if (w_we) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_s_fire) begin
                r_rd_cnt <= '0;
            end else if (w_issue) begin
                r_rd_cnt <= r_rd_cnt + CNT_W'(1);
            end
            // tag lines up with the registered read data
            r_tag0.valid <= w_issue;
            r_tag0.last  <= (r_rd_cnt == r_count - CNT_W'(1));
            r_tag0.idx   <= r_rd_cnt[IDX_W-1:0];
            if ((r_state == ST_OUT) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // search state and output payload
    always_ff @(posedge i_clk) begin
        if (w_s_fire && (w_op == OP_QUERY)) begin
            r_qx    <= i_s_tdata[ENTRY_W +: COORD_BITS];
            r_qy    <= i_s_tdata[ENTRY_W + COORD_BITS +: COORD_BITS];
            r_bound <= START_BOUND_SQ;
            r_found <= (r_count != '0);
            r_best  <= '0;
        end else if (w_tag3.valid) begin
            // entry 0 stands in when nothing beats the starting bound
            if ((w_tag3.idx == '0) || w_better) begin
                r_best.dist_sq <= w_dist;
                r_best.entry   <= w_entry3;
                r_best.idx     <= w_tag3.idx;
            end
            if (w_better) begin
                r_bound <= CMP_W'(w_dist);
            end
        end
        if ((r_state == ST_OUT) && w_out_free) begin
            r_m_found <= r_found;
            r_m_data  <= r_best;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_m_data);
    assign o_m_tuser  = r_m_found;

    `NBS_ASSERT(a_count_in_range, r_count <= CNT_W'(TABLE_DEPTH))
    `NBS_ASSERT_IMPLY(a_compare_only_in_walk, w_tag3.valid, r_state == ST_WALK)
    `NBS_ASSERT_IMPLY(a_pipe_empty_at_out, r_state == ST_OUT, !r_tag0.valid && !w_tag3.valid)
    `NBS_ASSERT_NEXT(a_append_grows, w_we, r_count == $past(r_count) + CNT_W'(1))

endmodule

/* src/nbs_ram.sv */
module nbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/nbs_dist.sv */
module nbs_dist (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  nbs_pkg::t_tag                     i_tag,
    input  nbs_pkg::t_entry                   i_entry,
    input  logic [nbs_pkg::COORD_BITS-1:0]    i_qx,
    input  logic [nbs_pkg::COORD_BITS-1:0]    i_qy,
    output nbs_pkg::t_tag                     o_tag,
    output nbs_pkg::t_entry                   o_entry,
    output logic [nbs_pkg::SQ_W-1:0]          o_sx,
    output logic [nbs_pkg::SQ_W-1:0]          o_sy
);
    import nbs_pkg::*;

    logic [MID_W-1:0] w_half;
    logic [MID_W-1:0] w_mx;
    logic [MID_W-1:0] w_my;
    logic [MID_W-1:0] w_qx;
    logic [MID_W-1:0] w_qy;
    logic [MID_W-1:0] w_dx;
    logic [MID_W-1:0] w_dy;

    t_tag             r_tag1;
    t_entry           r_entry1;
    logic [MID_W-1:0] r_dx;
    logic [MID_W-1:0] r_dy;
    t_tag             r_tag2;
    t_entry           r_entry2;
    logic [SQ_W-1:0]  r_sx;
    logic [SQ_W-1:0]  r_sy;

    // midpoint: half the length along the border's own axis
    always_comb begin
        w_half = MID_W'(i_entry.length >> 1);
        w_qx   = MID_W'(i_qx);
        w_qy   = MID_W'(i_qy);
        w_mx   = MID_W'(i_entry.x) + (i_entry.horizontal ? w_half : '0);
        w_my   = MID_W'(i_entry.y) + (i_entry.horizontal ? '0 : w_half);
        w_dx   = (w_mx >= w_qx) ? (w_mx - w_qx) : (w_qx - w_mx);
        w_dy   = (w_my >= w_qy) ? (w_my - w_qy) : (w_qy - w_my);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
        r_entry1 <= i_entry;
        r_dx     <= w_dx;
        r_dy     <= w_dy;
        r_entry2 <= r_entry1;
        r_sx     <= r_dx * r_dx;
        r_sy     <= r_dy * r_dy;
    end

    assign o_tag   = r_tag2;
    assign o_entry = r_entry2;
    assign o_sx    = r_sx;
    assign o_sy    = r_sy;

endmodule
